>>> rtl/rgbc_pkg.sv
// Shared types and constants of the RGB convolution core.
package rgbc_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int CIDX_W     = 6;
    localparam int ACT_W      = 2;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_K_W    = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int STREAM_W   = 48;

    localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [CFG_K_W-1:0] KSIZE_RST  = 3'd3;

    localparam logic [ACT_W-1:0] ACT_COEF  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PIXEL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KSIZE  = 2'd2;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } rgbc_lane_ctl_t;

endpackage

>>> rtl/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 7168
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/rgbc_lane.sv
// One color lane: registered multiply and accumulate over kernel taps.
module rgbc_lane #(
    parameter int ACC_W = 32
) (
    input  logic                        aclk,
    input  rgbc_pkg::rgbc_lane_ctl_t    ctl,
    input  logic [rgbc_pkg::PIX_W-1:0]  pix,
    input  logic signed [rgbc_pkg::COEF_W-1:0] coef,
    output logic signed [ACC_W-1:0]     acc
);
    import rgbc_pkg::*;

    localparam int PROD_W = PIX_W + COEF_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PIX_W:0]    pix_s;

    assign pix_s = {1'b0, pix};
    assign acc   = acc_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= pix_s * coef;
        end
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

endmodule

>>> rtl/rgbc_merge.sv
// Merge of the three lane sums: floor and saturate each to a byte.
module rgbc_merge #(
    parameter int ACC_W     = 32,
    parameter int FRAC_BITS = 10
) (
    input  logic signed [ACC_W-1:0]    sum_b,
    input  logic signed [ACC_W-1:0]    sum_g,
    input  logic signed [ACC_W-1:0]    sum_r,
    output logic [rgbc_pkg::PIX_W-1:0] out_b,
    output logic [rgbc_pkg::PIX_W-1:0] out_g,
    output logic [rgbc_pkg::PIX_W-1:0] out_r
);
    import rgbc_pkg::*;

    function automatic logic [PIX_W-1:0] sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] q;
        q = s >>> FRAC_BITS;
        if (s < 0) begin
            return '0;
        end else if (q > ACC_W'(255)) begin
            return 8'hFF;
        end
        return q[PIX_W-1:0];
    endfunction

    assign out_b = sat(sum_b);
    assign out_g = sat(sum_g);
    assign out_r = sat(sum_r);

endmodule

>>> rtl/rgb_convolution_edge_clamp_core.sv
// RGB convolution core with replicated image border, top level.
// Coefficient transfers, and pixel or flush transfers that yield no result, leave the core idle.
// A transfer that yields a result starts a serial pass over the side*side kernel taps
// (side = 2*radius+1), as one line-store read port feeds the MAC lanes; no new input is taken
// until the result is registered, which waits while m_tready holds off the previous result.
// Reset clears counters and coefficients and loads the default configuration; line store is not cleared.
module rgb_convolution_edge_clamp_core #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_KERNEL     = 7,
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbc_pkg::ADDR_W-1:0]     paddr,
    input  logic [rgbc_pkg::DATA_W-1:0]     pwdata,
    output logic [rgbc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // coef_index[5:0], coef_value[21:6], pixel_blue[29:22], pixel_green[37:30],
    // pixel_red[45:38], zero[47:46]
    input  logic [rgbc_pkg::STREAM_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [rgbc_pkg::ACT_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16], out_col[33:24],
    // out_row[45:34], zero[47:46]
    output logic [rgbc_pkg::STREAM_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import rgbc_pkg::*;

    localparam int DEPTH   = MAX_KERNEL * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int CDEPTH  = MAX_KERNEL * MAX_KERNEL;
    localparam int CIW     = $clog2(CDEPTH);
    localparam int KW      = $clog2(MAX_KERNEL + 1);
    localparam int XW      = $clog2(MAX_WIDTH + 1);
    localparam int CW      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SW      = ((AW > CFG_H_W) ? AW : CFG_H_W) + 3;
    localparam int ACC_W   = PIX_W + COEF_W + 2 + $clog2(CDEPTH);
    localparam int RMAX    = (MAX_KERNEL - 1) / 2;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DRAIN, S_EMIT} state_t;

    state_t state_reg;
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [CFG_K_W-1:0] ksize_reg;
    logic [CW-1:0] in_count_reg, out_count_reg;
    logic [AW-1:0] wr_addr_reg, base_reg;
    logic [XW-1:0] x_reg;
    logic [CFG_H_W-1:0] y_reg;
    logic [KW-1:0] tx_reg, ty_reg;
    logic [CIW-1:0] cidx_reg, cidx_d1_reg;
    logic vld1_reg, vld2_reg;
    logic [CDEPTH-1:0] coef_vld_reg;
    logic m_tvalid_reg, m_tlast_reg;
    logic [STREAM_W-1:0] m_tdata_reg;

    logic [XW-1:0] w_eff;
    logic [CFG_H_W-1:0] h_eff;
    logic [KW-1:0] r_eff, side;
    logic [CW-1:0] total, delay, in_next;
    logic cfg_wr, s_acc, pix_ok, coef_ok, emit_go, issue, last_tap, out_free;
    logic [ACT_W-1:0] act;
    logic [CIDX_W-1:0] s_cidx;
    logic [COEF_W-1:0] s_coef;
    logic [23:0] s_pix, line_q;
    logic [COEF_W-1:0] coef_q;
    logic signed [COEF_W-1:0] coef_use;
    logic [AW-1:0] raddr;
    rgbc_lane_ctl_t lane_ctl;
    logic signed [ACC_W-1:0] acc_b, acc_g, acc_r;
    logic [PIX_W-1:0] sat_b, sat_g, sat_r;
    logic signed [SW-1:0] sy, sx, sh, sw, ky, kx, py, px, dy, dx, off, asum;
    logic [CFG_H_W-1:0] y_out;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign act      = s_tuser;
    assign s_cidx   = s_tdata[5:0];
    assign s_coef   = s_tdata[21:6];
    assign s_pix    = {s_tdata[45:38], s_tdata[37:30], s_tdata[29:22]};

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_KSIZE:  prdata = DATA_W'(ksize_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = XW'(1);
        end else if ((XW + CFG_W_W)'(width_reg) > (XW + CFG_W_W)'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = CFG_H_W'(1);
        end else if (height_reg > CFG_H_W'(MAX_HEIGHT)) begin
            h_eff = CFG_H_W'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
        if ((KW + 2)'(ksize_reg[2:1]) > (KW + 2)'(RMAX)) begin
            r_eff = KW'(RMAX);
        end else begin
            r_eff = KW'(ksize_reg[2:1]);
        end
    end

    assign side    = KW'({r_eff, 1'b1});
    assign total   = CW'(w_eff * h_eff);
    assign delay   = CW'(r_eff * w_eff) + CW'(r_eff);
    assign pix_ok  = (act == ACT_PIXEL) && (in_count_reg < total);
    assign coef_ok = (act == ACT_COEF) && ((CIDX_W + CIW)'(s_cidx) < (CIDX_W + CIW)'(CDEPTH));
    assign in_next = pix_ok ? in_count_reg + CW'(1) : in_count_reg;
    assign emit_go = ((act == ACT_PIXEL) || (act == ACT_FLUSH)) && (out_count_reg < total)
                     && ((out_count_reg + delay < in_next) || (in_next == total));
    assign issue    = (state_reg == S_CALC);
    assign last_tap = (tx_reg == side - KW'(1)) && (ty_reg == side - KW'(1));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        sy = SW'(y_reg);
        sx = SW'(x_reg);
        sh = SW'(h_eff);
        sw = SW'(w_eff);
        ky = SW'(ty_reg) - SW'(r_eff);
        kx = SW'(tx_reg) - SW'(r_eff);
        py = sy + ky;
        px = sx + kx;
        if (py < 0) begin
            py = '0;
        end else if (py >= sh) begin
            py = sh - SW'(1);
        end
        if (px < 0) begin
            px = '0;
        end else if (px >= sw) begin
            px = sw - SW'(1);
        end
        dy   = py - sy;
        dx   = px - sx;
        off  = dy * sw + dx;
        asum = SW'(base_reg) + off;
        if (asum < 0) begin
            asum = asum + SW'(DEPTH);
        end else if (asum >= SW'(DEPTH)) begin
            asum = asum - SW'(DEPTH);
        end
        raddr = asum[AW-1:0];
    end

    rgbc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_line_ram (
        .aclk  (aclk),
        .we    (s_acc && pix_ok),
        .waddr (wr_addr_reg),
        .wdata (s_pix),
        .raddr (raddr),
        .rdata (line_q)
    );

    rgbc_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
        .aclk  (aclk),
        .we    (s_acc && coef_ok),
        .waddr (CIW'(s_cidx)),
        .wdata (s_coef),
        .raddr (cidx_reg),
        .rdata (coef_q)
    );

    assign coef_use = coef_vld_reg[cidx_d1_reg] ? coef_q : '0;

    assign lane_ctl.clear  = s_acc && emit_go;
    assign lane_ctl.mul_en = vld1_reg;
    assign lane_ctl.acc_en = vld2_reg;

    rgbc_lane #(.ACC_W(ACC_W)) u_lane_b (
        .aclk(aclk), .ctl(lane_ctl), .pix(line_q[7:0]), .coef(coef_use), .acc(acc_b)
    );
    rgbc_lane #(.ACC_W(ACC_W)) u_lane_g (
        .aclk(aclk), .ctl(lane_ctl), .pix(line_q[15:8]), .coef(coef_use), .acc(acc_g)
    );
    rgbc_lane #(.ACC_W(ACC_W)) u_lane_r (
        .aclk(aclk), .ctl(lane_ctl), .pix(line_q[23:16]), .coef(coef_use), .acc(acc_r)
    );

    rgbc_merge #(.ACC_W(ACC_W), .FRAC_BITS(COEF_FRAC_BITS)) u_merge (
        .sum_b(acc_b), .sum_g(acc_g), .sum_r(acc_r),
        .out_b(sat_b), .out_g(sat_g), .out_r(sat_r)
    );

    assign y_out = y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            ksize_reg     <= KSIZE_RST;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            wr_addr_reg   <= '0;
            base_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            cidx_reg      <= '0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            coef_vld_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            vld1_reg    <= issue;
            vld2_reg    <= vld1_reg;
            cidx_d1_reg <= cidx_reg;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        if (coef_ok) begin
                            coef_vld_reg[CIW'(s_cidx)] <= 1'b1;
                        end
                        if (pix_ok) begin
                            in_count_reg <= in_next;
                            wr_addr_reg  <= (wr_addr_reg == AW'(DEPTH - 1)) ? '0
                                            : wr_addr_reg + AW'(1);
                        end
                        if (emit_go) begin
                            tx_reg    <= '0;
                            ty_reg    <= '0;
                            cidx_reg  <= '0;
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    cidx_reg <= cidx_reg + CIW'(1);
                    if (tx_reg == side - KW'(1)) begin
                        tx_reg <= '0;
                        ty_reg <= ty_reg + KW'(1);
                    end else begin
                        tx_reg <= tx_reg + KW'(1);
                    end
                    if (last_tap) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!vld1_reg && !vld2_reg) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, y_out[ROW_W-1:0], COL_W'(x_reg),
                                         sat_r, sat_g, sat_b};
                        m_tlast_reg  <= (out_count_reg + CW'(1) == total);
                        state_reg    <= S_IDLE;
                        if (out_count_reg + CW'(1) == total) begin
                            out_count_reg <= '0;
                            in_count_reg  <= '0;
                            wr_addr_reg   <= '0;
                            base_reg      <= '0;
                            x_reg         <= '0;
                            y_reg         <= '0;
                        end else begin
                            out_count_reg <= out_count_reg + CW'(1);
                            base_reg      <= (base_reg == AW'(DEPTH - 1)) ? '0
                                             : base_reg + AW'(1);
                            if (x_reg + XW'(1) == w_eff) begin
                                x_reg <= '0;
                                y_reg <= y_reg + CFG_H_W'(1);
                            end else begin
                                x_reg <= x_reg + XW'(1);
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cfg_wr && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT)
                           || (paddr[3:2] == REG_KSIZE))) begin
                unique case (paddr[3:2])
                    REG_WIDTH:  width_reg  <= pwdata[CFG_W_W-1:0];
                    REG_HEIGHT: height_reg <= pwdata[CFG_H_W-1:0];
                    REG_KSIZE:  ksize_reg  <= pwdata[CFG_K_W-1:0];
                    default:    ;
                endcase
                in_count_reg  <= '0;
                out_count_reg <= '0;
                wr_addr_reg   <= '0;
                base_reg      <= '0;
                x_reg         <= '0;
                y_reg         <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
